// File: rtl/fsr_pkg.sv
`default_nettype none

package fsr_pkg;

    localparam int DATA_W = 8;
    localparam int USER_W = 3;
    localparam int POS_W  = 16;

    localparam int USER_EMPTY     = 0;
    localparam int USER_RESPONDER = 1;
    localparam int USER_NEW_FLOW  = 2;

    localparam logic [DATA_W-1:0] FLAP_START       = 8'h2A;
    localparam logic [DATA_W-1:0] FLAP_TYPE_SIGNON = 8'h01;
    localparam logic [DATA_W-1:0] FLAP_TYPE_DATA   = 8'h02;
    localparam logic [DATA_W-1:0] FLAP_TYPE_TLV    = 8'h04;
    localparam logic [DATA_W-1:0] SIGNON_WORD_LAST = 8'h01;
    localparam logic [DATA_W-1:0] BYTE_ZERO        = 8'h00;

    localparam logic [POS_W-1:0] FAM_SIGNON       = 16'h0017;
    localparam logic [POS_W-1:0] FAM_GENERIC      = 16'h0001;
    localparam logic [POS_W-1:0] SUB_SIGNON_REPLY = 16'h0007;
    localparam logic [POS_W-1:0] SUB_SERVER_READY = 16'h0003;

    localparam logic [POS_W-1:0] POS_START       = 16'd0;
    localparam logic [POS_W-1:0] POS_TYPE        = 16'd1;
    localparam logic [POS_W-1:0] POS_HLEN_HI     = 16'd4;
    localparam logic [POS_W-1:0] POS_HLEN_LO     = 16'd5;
    localparam logic [POS_W-1:0] POS_FAM_HI      = 16'd6;
    localparam logic [POS_W-1:0] POS_FAM_LO      = 16'd7;
    localparam logic [POS_W-1:0] POS_SUB_HI      = 16'd8;
    localparam logic [POS_W-1:0] POS_SUB_LO      = 16'd9;
    localparam logic [POS_W-1:0] POS_SIGNON_HI   = 16'd16;
    localparam logic [POS_W-1:0] POS_SIGNON_LO   = 16'd17;
    localparam logic [POS_W-1:0] POS_MAX         = 16'hFFFF;

    localparam logic [POS_W-1:0] SIGNON_SIZE     = 16'd10;
    localparam logic [POS_W-1:0] SIGNON_HLEN     = 16'd4;
    localparam logic [POS_W-1:0] HEADER_SIZE     = 16'd6;
    localparam logic [POS_W-1:0] MIN_COOKIE_SIZE = 16'd16;
    localparam logic [POS_W-1:0] FNAC_SIGNON_HDR = 16'd18;

    localparam logic [1:0] TLV_IDX_IDLE   = 2'd0;
    localparam logic [1:0] TLV_IDX_LEN_HI = 2'd2;
    localparam logic [1:0] TLV_IDX_LEN_LO = 2'd3;

    typedef enum logic [1:0] {
        VERDICT_IN_PROGRESS = 2'd0,
        VERDICT_NO_MATCH    = 2'd1,
        VERDICT_MATCH       = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              last_byte;
        logic              empty_packet;
        logic              from_responder;
        logic              new_flow;
    } beat_t;

    typedef struct packed {
        logic [POS_W-1:0]  byte_position;
        logic [DATA_W-1:0] frame_type;
        logic [POS_W-1:0]  header_length;
        logic [POS_W-1:0]  fnac_family;
        logic [POS_W-1:0]  fnac_subtype;
        logic [POS_W-1:0]  signon_length;
        logic [POS_W-1:0]  tlv_remaining;
        logic [1:0]        tlv_header_index;
        logic              packet_failed;
    } pkt_t;

endpackage

`default_nettype wire

// File: rtl/flap_session_recognizer_unit.sv
// channel  dir  tdata                    tlast      tuser
// s_       in   [7:0] data_byte          last_byte  [0] empty_packet [1] from_responder
//                                                   [2] new_flow
// m_       out  [1:0] verdict, [7:2] 0   -          -
//
// one beat per cycle in unless held by a stall; a result passes the input register,
// then the result register, through the single parse and judge pass
// aresetn is synchronous and clears the flow phase and all packet state
// a stalled result register holds back only beats that end a packet; other beats
// keep flowing
`default_nettype none

module flap_session_recognizer_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [fsr_pkg::DATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  logic                       s_tlast,
    input  logic [fsr_pkg::USER_W-1:0] s_tuser,  // [0] empty_packet, [1] from_responder, [2] new_flow
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [fsr_pkg::DATA_W-1:0] m_tdata   // [1:0] verdict, [7:2] zero
);
    import fsr_pkg::*;

    logic              in_valid_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic              in_last_reg;
    logic [USER_W-1:0] in_user_reg;
    logic              out_valid_reg, out_valid_next;
    verdict_t          verdict_reg, verdict_next;

    beat_t    beat;
    pkt_t     taken;
    logic     phase_eff;
    verdict_t judged;
    logic     produces;
    logic     advance;

    assign beat.data_byte      = in_data_reg;
    assign beat.last_byte      = in_last_reg;
    assign beat.empty_packet   = in_user_reg[USER_EMPTY];
    assign beat.from_responder = in_user_reg[USER_RESPONDER];
    assign beat.new_flow       = in_user_reg[USER_NEW_FLOW];

    assign produces = beat.empty_packet || beat.last_byte;
    assign advance  = in_valid_reg && (!produces || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    fsr_track u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .beat      (beat),
        .taken     (taken),
        .phase_eff (phase_eff)
    );

    fsr_judge u_judge (
        .phase   (phase_eff),
        .taken   (taken),
        .verdict (judged)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        verdict_next   = verdict_reg;
        if (advance && produces) begin
            out_valid_next = 1'b1;
            verdict_next   = (beat.empty_packet || !beat.from_responder) ?
                             VERDICT_IN_PROGRESS : judged;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) in_valid_reg <= 1'b1;
            else if (advance)         in_valid_reg <= 1'b0;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
            in_user_reg <= s_tuser;
        end
        verdict_reg <= verdict_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(DATA_W-2){1'b0}}, verdict_reg};

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && produces |=> m_tvalid)
        else $error("packet end beat left no result");

    a_initiator_in_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && produces && (beat.empty_packet || !beat.from_responder)
        |=> m_tdata[1:0] == VERDICT_IN_PROGRESS)
        else $error("initiator or empty beat gave a final verdict");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && produces && out_valid_reg && !m_tready |=> in_valid_reg)
        else $error("pending packet end beat dropped under stall");

endmodule

`default_nettype wire

// File: rtl/fsr_track.sv
`default_nettype none

module fsr_track (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  fsr_pkg::beat_t beat,
    output fsr_pkg::pkt_t  taken,
    output logic          phase_eff
);
    import fsr_pkg::*;

    pkt_t              pkt_reg, pkt_next;
    logic              phase_reg, phase_next;
    logic [DATA_W-1:0] len_high_reg, len_high_next;
    pkt_t              base;
    logic [DATA_W-1:0] base_high, taken_high;
    logic [POS_W-1:0]  p;
    logic [DATA_W-1:0] b;

    // per-byte parse on top of the state, cleared first for a new flow
    always_comb begin
        base       = beat.new_flow ? '0 : pkt_reg;
        base_high  = beat.new_flow ? '0 : len_high_reg;
        phase_eff  = beat.new_flow ? 1'b0 : phase_reg;
        taken      = base;
        taken_high = base_high;
        p          = base.byte_position;
        b          = beat.data_byte;

        if (p == POS_START && b != FLAP_START) taken.packet_failed = 1'b1;
        if (p == POS_TYPE)    taken.frame_type = b;
        if (p == POS_HLEN_HI) taken.header_length[15:8] = b;
        if (p == POS_HLEN_LO) taken.header_length[7:0]  = b;

        if (!phase_eff) begin
            if (p == POS_TYPE && b != FLAP_TYPE_SIGNON) taken.packet_failed = 1'b1;
            if (p >= POS_FAM_HI && p <= POS_SUB_HI && b != BYTE_ZERO)
                taken.packet_failed = 1'b1;
            if (p == POS_SUB_LO && b != SIGNON_WORD_LAST) taken.packet_failed = 1'b1;
        end else begin
            if (p == POS_FAM_HI)    taken.fnac_family[15:8]   = b;
            if (p == POS_FAM_LO)    taken.fnac_family[7:0]    = b;
            if (p == POS_SUB_HI)    taken.fnac_subtype[15:8]  = b;
            if (p == POS_SUB_LO)    taken.fnac_subtype[7:0]   = b;
            if (p == POS_SIGNON_HI) taken.signon_length[15:8] = b;
            if (p == POS_SIGNON_LO) taken.signon_length[7:0]  = b;
            if (p >= HEADER_SIZE) begin
                priority if (base.tlv_remaining != '0) begin
                    taken.tlv_remaining = base.tlv_remaining - 16'd1;
                end else if (base.tlv_header_index == TLV_IDX_LEN_HI) begin
                    taken_high             = b;
                    taken.tlv_header_index = TLV_IDX_LEN_LO;
                end else if (base.tlv_header_index == TLV_IDX_LEN_LO) begin
                    taken.tlv_remaining    = {base_high, b};
                    taken.tlv_header_index = TLV_IDX_IDLE;
                end else begin
                    taken.tlv_header_index = base.tlv_header_index + 2'd1;
                end
            end
        end

        if (p != POS_MAX) taken.byte_position = p + 16'd1;
    end

    always_comb begin
        pkt_next      = pkt_reg;
        len_high_next = len_high_reg;
        phase_next    = phase_reg;
        if (step) begin
            phase_next = phase_eff;
            if (beat.empty_packet) begin
                pkt_next      = '0;
                len_high_next = '0;
            end else if (beat.last_byte) begin
                pkt_next      = '0;
                len_high_next = '0;
                if (beat.from_responder) phase_next = 1'b1;
            end else begin
                pkt_next      = taken;
                len_high_next = taken_high;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_reg      <= '0;
            len_high_reg <= '0;
            phase_reg    <= 1'b0;
        end else begin
            pkt_reg      <= pkt_next;
            len_high_reg <= len_high_next;
            phase_reg    <= phase_next;
        end
    end

    a_clear_after_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (beat.empty_packet || beat.last_byte) |=> pkt_reg.byte_position == '0)
        else $error("packet state not cleared after verdict");

    a_cookie_after_responder: assert property (@(posedge aclk) disable iff (!aresetn)
        step && beat.last_byte && !beat.empty_packet && beat.from_responder |=> phase_reg)
        else $error("phase not in cookie after responder packet");

    a_signon_phase_no_fnac: assert property (@(posedge aclk) disable iff (!aresetn)
        !phase_reg |-> pkt_reg.tlv_header_index == TLV_IDX_IDLE && pkt_reg.fnac_family == '0)
        else $error("fnac state moved during signon phase");

endmodule

`default_nettype wire

// File: rtl/fsr_judge.sv
`default_nettype none

module fsr_judge (
    input  logic              phase,
    input  fsr_pkg::pkt_t     taken,
    output fsr_pkg::verdict_t verdict
);
    import fsr_pkg::*;

    logic [POS_W-1:0] size;
    logic             frame_ok;
    logic             body_ok;

    always_comb begin
        size     = taken.byte_position;
        frame_ok = !taken.packet_failed && size >= MIN_COOKIE_SIZE &&
                   taken.header_length == size - HEADER_SIZE;
        body_ok  = 1'b0;
        if (taken.frame_type == FLAP_TYPE_DATA) begin
            if (taken.fnac_family == FAM_SIGNON)
                body_ok = taken.fnac_subtype == SUB_SIGNON_REPLY &&
                          size >= FNAC_SIGNON_HDR &&
                          taken.signon_length == size - FNAC_SIGNON_HDR;
            else if (taken.fnac_family == FAM_GENERIC)
                body_ok = taken.fnac_subtype == SUB_SERVER_READY;
        end else if (taken.frame_type == FLAP_TYPE_TLV) begin
            body_ok = taken.tlv_header_index == TLV_IDX_IDLE && taken.tlv_remaining == '0;
        end

        if (!phase) begin
            verdict = (!taken.packet_failed && size == SIGNON_SIZE &&
                       taken.header_length == SIGNON_HLEN) ?
                      VERDICT_IN_PROGRESS : VERDICT_NO_MATCH;
        end else begin
            verdict = (frame_ok && body_ok) ? VERDICT_MATCH : VERDICT_NO_MATCH;
        end
    end

endmodule

`default_nettype wire
